/* sv/hidkb_pkg.sv */
// hidkb_pkg: sizes, register indexes and controller/datapath words for the
// hid keyboard report builder
// no dependencies
package hidkb_pkg;

  localparam int KEY_SLOTS    = 6;
  localparam int BITMAP_CODES = 256;
  localparam int REPORT_SLOTS = 6;
  localparam int REPORT_USED  = (KEY_SLOTS < REPORT_SLOTS) ? KEY_SLOTS : REPORT_SLOTS;
  localparam int SLOT_W       = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int NKRO_WORDS   = 4;

  localparam int CODE_W      = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CODE_W-1:0] MOD_FIRST = 8'hE0;
  localparam logic [CODE_W-1:0] MOD_LAST  = 8'hE7;

  localparam logic [CFG_INDEX_W-1:0] REG_BOOT_ENABLE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NKRO_ENABLE = 8'd1;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic scan_step;
    logic apply;
    logic out_load;
  } hidkb_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic scan_last;
    logic changed;
    logic out_busy;
  } hidkb_stat_t;

endpackage

/* sv/hidkb_ifs.sv */
// hidkb_ifs: valid/ready channels for key events, reports and register writes
// depends on hidkb_pkg
interface hidkb_key_if;
  logic                      valid;
  logic                      ready;
  logic [hidkb_pkg::CODE_W-1:0] key_code;
  logic                      pressed;

  modport source (output valid, output key_code, output pressed, input ready);
  modport sink   (input valid, input key_code, input pressed, output ready);
endinterface

interface hidkb_rpt_if;
  logic        valid;
  logic        ready;
  logic [63:0] boot_report;
  logic [63:0] nkro_bits_0;
  logic [63:0] nkro_bits_1;
  logic [63:0] nkro_bits_2;
  logic [63:0] nkro_bits_3;

  modport source (output valid, output boot_report, output nkro_bits_0,
                  output nkro_bits_1, output nkro_bits_2, output nkro_bits_3,
                  input ready);
  modport sink   (input valid, input boot_report, input nkro_bits_0,
                  input nkro_bits_1, input nkro_bits_2, input nkro_bits_3,
                  output ready);
endinterface

interface hidkb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hidkb_pkg::CFG_INDEX_W-1:0] index;
  logic [hidkb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/hidkb_ctrl.sv */
// hidkb_ctrl: sequencer for one key event: capture, slot scan, update, emit
// depends on hidkb_pkg
module hidkb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  hidkb_pkg::hidkb_stat_t st,
  output hidkb_pkg::hidkb_cmd_t  cmd
);
  import hidkb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_EMIT} state_t;

  state_t state;
  state_t state_next;
  logic   in_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.in_ready  = in_ready;
    unique case (state)
      S_IDLE: begin
        if (st.in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!st.changed) begin
          state_next = S_IDLE;
        end else if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

/* sv/hidkb_dp.sv */
// hidkb_dp: key slots, modifier byte, rollover bitmap, config and report register
// depends on hidkb_pkg and hidkb_ifs
module hidkb_dp (
  input  logic                   clk,
  input  logic                   rst,
  hidkb_key_if.sink              key,
  hidkb_rpt_if.source            report,
  hidkb_cfg_if.sink              cfg,
  input  hidkb_pkg::hidkb_cmd_t  cmd,
  output hidkb_pkg::hidkb_stat_t st
);
  import hidkb_pkg::*;

  logic              boot_en;
  logic              nkro_en;
  logic [CODE_W-1:0] code;
  logic              down;
  logic [SLOT_W-1:0] scan_idx;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              free_ok;
  logic [SLOT_W-1:0] free_idx;
  logic              changed;
  logic [7:0]        modifier_bits;
  logic [CODE_W-1:0] key_slots [KEY_SLOTS];
  logic [63:0]       bitmap [NKRO_WORDS];
  logic              out_valid;

  logic              scan_last;
  logic [CODE_W-1:0] scan_slot;
  logic              is_mod;
  logic              mod_now;
  logic              nkro_in;
  logic [1:0]        word;
  logic              bit_now;
  logic              boot_chg;
  logic              nkro_chg;
  logic [63:0]       boot_word;

  assign key.ready  = cmd.in_ready;
  assign cfg.ready  = 1'b1;
  assign report.valid = out_valid;

  assign scan_last = (scan_idx == SLOT_W'(KEY_SLOTS - 1));
  assign scan_slot = key_slots[scan_idx];

  assign is_mod  = (code >= MOD_FIRST) && (code <= MOD_LAST);
  // modifier bit is the low three bits of the code
  assign mod_now = modifier_bits[code[2:0]];
  assign nkro_in = ({1'b0, code} < 9'(BITMAP_CODES));
  assign word    = code[7:6];
  assign bit_now = bitmap[word][code[5:0]];

  always_comb begin
    boot_chg = 1'b0;
    if (is_mod) boot_chg = (mod_now != down);
    else if (down) boot_chg = !hit && free_ok;
    else boot_chg = hit;
    boot_chg = boot_chg && boot_en && (code != '0);
  end

  assign nkro_chg = nkro_en && nkro_in && (code != '0) && (bit_now != down);

  always_comb begin
    boot_word      = '0;
    boot_word[7:0] = modifier_bits;
    for (int i = 0; i < REPORT_USED; i++) begin
      boot_word[8*(i+2) +: 8] = key_slots[SLOT_W'(i)];
    end
  end

  assign st.in_valid  = key.valid;
  assign st.scan_last = scan_last;
  assign st.changed   = changed;
  assign st.out_busy  = out_valid && !report.ready;

  // event capture and slot scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code     <= key.key_code;
      down     <= key.pressed;
      scan_idx <= '0;
      hit      <= 1'b0;
      free_ok  <= 1'b0;
    end else if (cmd.scan_step) begin
      // first match wins, highest free slot wins
      if ((scan_slot == code) && !hit) begin
        hit     <= 1'b1;
        hit_idx <= scan_idx;
      end
      if (scan_slot == '0) begin
        free_ok  <= 1'b1;
        free_idx <= scan_idx;
      end
      scan_idx <= scan_last ? '0 : scan_idx + SLOT_W'(1);
    end
  end

  // report state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_en       <= 1'b1;
      nkro_en       <= 1'b1;
      changed       <= 1'b0;
      modifier_bits <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) key_slots[i] <= '0;
      for (int w = 0; w < NKRO_WORDS; w++) bitmap[w] <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_BOOT_ENABLE: boot_en <= cfg.data[0];
          REG_NKRO_ENABLE: nkro_en <= cfg.data[0];
          default: ;
        endcase
      end
      if (cmd.apply) begin
        changed <= boot_chg || nkro_chg;
        if (boot_chg) begin
          if (is_mod) modifier_bits[code[2:0]] <= down;
          else if (down) key_slots[free_idx] <= code;
          else key_slots[hit_idx] <= '0;
        end
        if (nkro_chg) bitmap[word][code[5:0]] <= down;
      end
    end
  end

  // report register, may be reloaded in the cycle its word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      report.boot_report <= boot_en ? boot_word : 64'd0;
      report.nkro_bits_0 <= nkro_en ? bitmap[0] : 64'd0;
      report.nkro_bits_1 <= nkro_en ? bitmap[1] : 64'd0;
      report.nkro_bits_2 <= nkro_en ? bitmap[2] : 64'd0;
      report.nkro_bits_3 <= nkro_en ? bitmap[3] : 64'd0;
    end
  end

`ifndef SYNTH
  a_hit_matches: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && hit |-> key_slots[hit_idx] == code)
    else $error("scan hit does not point at the key code");

  a_press_unique: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && boot_chg && !is_mod && down |-> !hit && key_slots[free_idx] == '0)
    else $error("press would duplicate a key or overwrite a slot");

  a_press_stored: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && boot_chg && !is_mod && down |=> key_slots[$past(free_idx)] == $past(code))
    else $error("pressed key not stored in its slot");

  a_emit_on_change: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> changed && !st.out_busy)
    else $error("report loaded without a change or over an untaken word");
`endif

endmodule

/* sv/hid_keyboard_report_builder.sv */
// hid_keyboard_report_builder: top level, controller plus datapath
// depends on hidkb_pkg, hidkb_ifs, hidkb_ctrl and hidkb_dp
//
// Each key event passes through capture, a slot scan that visits every key
// slot in turn, an update of the report state and an emit step before the
// block is ready again. A report word is sent only when the event changed the
// report; it sits in an output register while the next event is accepted
// and worked on, and that event's report waits only if the previous word is
// still untaken. Register writes are taken in any cycle (ready is always
// high) and are meant to be made only while no event is in flight.
module hid_keyboard_report_builder (
  input logic         clk,
  input logic         rst,
  hidkb_key_if.sink   key,
  hidkb_rpt_if.source report,
  hidkb_cfg_if.sink   cfg
);
  import hidkb_pkg::*;

  hidkb_cmd_t  cmd;
  hidkb_stat_t st;

  hidkb_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  hidkb_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .key    (key),
    .report (report),
    .cfg    (cfg),
    .cmd    (cmd),
    .st     (st)
  );

endmodule

/* bench/hid_keyboard_report_builder_tb.sv */
// hid_keyboard_report_builder_tb: self-checking bench for the key report builder,
// boot slots, modifier byte and rollover bitmap under all enable settings
// depends on hidkb_pkg, hidkb_ifs and the hid_keyboard_report_builder rtl
module hid_keyboard_report_builder_tb;
  import hidkb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 3 + KEY_SLOTS + 8;
  localparam int POOL_SIZE   = 10;

  typedef struct {
    logic [63:0] boot;
    logic [63:0] nkro [NKRO_WORDS];
  } key_report_t;

  logic clk = 1'b0;
  logic rst;

  hidkb_key_if key_ch ();
  hidkb_rpt_if rpt_ch ();
  hidkb_cfg_if cfg_ch ();

  hid_keyboard_report_builder u_top (
    .clk    (clk),
    .rst    (rst),
    .key    (key_ch),
    .report (rpt_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // shadow of the block's state and enables
  logic              boot_on;
  logic              nkro_on;
  logic [7:0]        mod_byte;
  logic [CODE_W-1:0] slot_code [KEY_SLOTS];
  logic [63:0]       rollover [NKRO_WORDS];

  key_report_t pending_reports [$];
  int          mismatch_count = 0;
  int          report_count = 0;
  bit          source_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int          stall_left = 0;
  logic [CODE_W-1:0] code_pool [POOL_SIZE];

  task automatic note_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_state();
    boot_on  = 1'b1;
    nkro_on  = 1'b1;
    mod_byte = '0;
    foreach (slot_code[i]) slot_code[i] = '0;
    foreach (rollover[w]) rollover[w] = '0;
  endfunction

  // updates the shadow state; returns 1 when the event changed the report
  function automatic bit apply_key_event(input logic [CODE_W-1:0] code, input logic down,
                                         output key_report_t rpt);
    bit changed;
    bit dup;
    bit done;
    int free_idx;
    logic [1:0] w;
    changed = 1'b0;
    dup = 1'b0;
    done = 1'b0;
    free_idx = -1;
    if (code == '0) return 1'b0;
    if (boot_on) begin
      if (code >= MOD_FIRST && code <= MOD_LAST) begin
        // modifier bit is the low three bits of the code
        if (mod_byte[code[2:0]] != down) begin
          mod_byte[code[2:0]] = down;
          changed = 1'b1;
        end
      end else if (down) begin
        // highest free slot wins, a key already held blocks the press
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (slot_code[i] == code) dup = 1'b1;
          if (slot_code[i] == '0) free_idx = i;
        end
        if (!dup && free_idx >= 0) begin
          slot_code[SLOT_W'(free_idx)] = code;
          changed = 1'b1;
        end
      end else begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (!done && slot_code[i] == code) begin
            slot_code[i] = '0;
            done = 1'b1;
            changed = 1'b1;
          end
        end
      end
    end
    if (nkro_on && int'(code) < BITMAP_CODES) begin
      w = code[7:6];
      if (rollover[w][code[5:0]] != down) begin
        rollover[w][code[5:0]] = down;
        changed = 1'b1;
      end
    end
    rpt.boot = '0;
    if (boot_on) begin
      rpt.boot[7:0] = mod_byte;
      for (int i = 0; i < REPORT_USED; i++) rpt.boot[8*(i+2) +: 8] = slot_code[i];
    end
    for (int i = 0; i < NKRO_WORDS; i++) rpt.nkro[i] = nkro_on ? rollover[i] : 64'd0;
    return changed;
  endfunction

  task automatic send_key(input logic [CODE_W-1:0] code, input logic down);
    int gap;
    key_report_t rpt;
    gap = 0;
    if (source_idle && $urandom_range(0, 2) == 0) gap = idle_len();
    if (gap > 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.key_code <= code;
    key_ch.pressed  <= down;
    do @(posedge clk); while (!key_ch.ready);
    if (apply_key_event(code, down, rpt)) pending_reports.push_back(rpt);
  endtask

  // lets every expected report drain, then waits out events with no report
  task automatic drain();
    key_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // writes both enables, then a write to an unused index that must be ignored
  task automatic set_modes(input logic boot, input logic nkro);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = CFG_DATA_W'($urandom);
    wdata[0] = boot;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_BOOT_ENABLE;
    cfg_ch.data  <= wdata;
    do @(posedge clk); while (!cfg_ch.ready);
    boot_on = boot;
    wdata = CFG_DATA_W'($urandom);
    wdata[0] = nkro;
    cfg_ch.index <= REG_NKRO_ENABLE;
    cfg_ch.data  <= wdata;
    do @(posedge clk); while (!cfg_ch.ready);
    nkro_on = nkro;
    cfg_ch.index <= CFG_INDEX_W'($urandom_range(2, 255));
    cfg_ch.data  <= CFG_DATA_W'($urandom);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void refill_pool();
    foreach (code_pool[i]) begin
      if ($urandom_range(0, 3) == 0) code_pool[i] = CODE_W'(MOD_FIRST + $urandom_range(0, 7));
      else code_pool[i] = CODE_W'($urandom_range(1, 255));
    end
  endfunction

  // report sink with random stalls
  always @(posedge clk) begin
    if (rst) begin
      rpt_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rpt_ch.ready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_len() - 1;
      rpt_ch.ready <= 1'b0;
    end else begin
      rpt_ch.ready <= 1'b1;
    end
  end

  // compares each report word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rpt_ch.valid && rpt_ch.ready) begin
      report_count++;
      if (pending_reports.size() == 0) begin
        note_mismatch($sformatf("report %0d arrived with none expected", report_count));
      end else begin
        automatic key_report_t want = pending_reports.pop_front();
        automatic logic [63:0] got [NKRO_WORDS];
        got[0] = rpt_ch.nkro_bits_0;
        got[1] = rpt_ch.nkro_bits_1;
        got[2] = rpt_ch.nkro_bits_2;
        got[3] = rpt_ch.nkro_bits_3;
        if (rpt_ch.boot_report !== want.boot)
          note_mismatch($sformatf("report %0d boot_report got %h want %h",
                                  report_count, rpt_ch.boot_report, want.boot));
        for (int w = 0; w < NKRO_WORDS; w++)
          if (got[w] !== want.nkro[w])
            note_mismatch($sformatf("report %0d nkro_bits_%0d got %h want %h",
                                    report_count, w, got[w], want.nkro[w]));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic test_boot_extremes();
    source_idle = 1'b1;
    sink_idle   = 1'b1;
    send_key(8'h00, 1'b1);
    send_key(8'h00, 1'b0);
    send_key(MOD_FIRST, 1'b1);
    send_key(MOD_LAST, 1'b1);
    send_key(MOD_FIRST, 1'b1);
    send_key(MOD_FIRST, 1'b0);
    send_key(MOD_FIRST, 1'b0);
    // codes right at the edges of the modifier range go to slots
    send_key(8'hDF, 1'b1);
    send_key(8'hE8, 1'b1);
    send_key(8'hFF, 1'b1);
    send_key(8'h01, 1'b1);
    send_key(8'h04, 1'b1);
    send_key(8'h05, 1'b1);
    // slots full: a press changes only the bitmap until a release frees a slot
    send_key(8'h06, 1'b1);
    send_key(8'hFF, 1'b0);
    send_key(8'h07, 1'b1);
    drain();
  endtask

  task automatic test_mode_switching();
    set_modes(1'b1, 1'b0);
    send_key(8'h08, 1'b1);
    send_key(8'h06, 1'b0);
    send_key(CODE_W'(MOD_FIRST + 3), 1'b1);
    drain();
    set_modes(1'b0, 1'b1);
    send_key(8'h06, 1'b0);
    send_key(8'h06, 1'b0);
    drain();
    set_modes(1'b0, 1'b0);
    send_key(8'h10, 1'b1);
    drain();
  endtask

  task automatic typing_phase(input logic boot, input logic nkro, input int count,
                              input bit src_gaps, input bit sink_gaps);
    int taken;
    int r;
    logic [CODE_W-1:0] code;
    logic down;
    taken = 0;
    set_modes(boot, nkro);
    source_idle = src_gaps;
    sink_idle   = sink_gaps;
    refill_pool();
    while (taken < count) begin
      r = $urandom_range(0, 99);
      if (r < 72) code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 76) code = '0;
      else code = CODE_W'($urandom_range(0, 255));
      down = ($urandom_range(0, 99) < 55);
      send_key(code, down);
      if (code != '0 || !(boot || nkro)) taken++;
      if (taken % 60 == 59) refill_pool();
    end
    drain();
  endtask

  task automatic test_random_typing();
    typing_phase(1'b1, 1'b1, 200, 1'b1, 1'b1);
    typing_phase(1'b1, 1'b0, 150, 1'b1, 1'b1);
    typing_phase(1'b0, 1'b1, 120, 1'b1, 1'b1);
    typing_phase(1'b0, 1'b0, 20, 1'b1, 1'b0);
    typing_phase(1'b1, 1'b1, 150, 1'b0, 1'b0);
    typing_phase(1'b1, 1'b1, 100, 1'b0, 1'b1);
  endtask

  initial begin
    rst             <= 1'b1;
    key_ch.valid    <= 1'b0;
    key_ch.key_code <= '0;
    key_ch.pressed  <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    clear_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_boot_extremes();
    test_mode_switching();
    test_random_typing();
    drain();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/hidkb_pkg.sv
sv/hidkb_ifs.sv
sv/hidkb_ctrl.sv
sv/hidkb_dp.sv
sv/hid_keyboard_report_builder.sv
bench/hid_keyboard_report_builder_tb.sv
